/* rtl/core/uqt_pkg.sv */
// Shared types and constants for the user quota table.
package uqt_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned UidW = 32;
  localparam int unsigned CntW = 64;

  typedef enum logic [2:0] {
    OP_CHK_BLK = 3'd0,
    OP_CHK_INO = 3'd1,
    OP_ADD_BLK = 3'd2,
    OP_ADD_INO = 3'd3,
    OP_SET     = 3'd4,
    OP_LOOKUP  = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MATCH  = 2'd1,
    ST_UPDATE = 2'd2,
    ST_OUT    = 2'd3
  } state_t;

  typedef struct packed {
    logic [CntW-1:0] bused;
    logic [CntW-1:0] bsoft;
    logic [CntW-1:0] bhard;
    logic [CntW-1:0] iused;
    logic [CntW-1:0] isoft;
    logic [CntW-1:0] ihard;
  } entry_t;

  // request data handed to every cell
  typedef struct packed {
    op_t             op;
    logic [UidW-1:0] uid;
    logic [CntW-1:0] amount;
    logic [CntW-1:0] bsoft;
    logic [CntW-1:0] bhard;
    logic [CntW-1:0] isoft;
    logic [CntW-1:0] ihard;
  } req_t;

  // control from the sequencer to the cells
  typedef struct packed {
    logic hit_write;   // update matched cell
    logic alloc_write; // allocate into cell at alloc index
  } cell_ctl_t;

endpackage

/* rtl/core/uqt_cell.sv */
// One table cell: key, counters and limits, with its own tag compare.
module uqt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_use,
  input  logic               alloc_sel,
  input  uqt_pkg::cell_ctl_t ctl,
  input  uqt_pkg::req_t      req,
  input  uqt_pkg::entry_t    chain_in,
  input  logic               hit_in,
  output uqt_pkg::entry_t    chain_out,
  output logic               hit_out
);

  logic [uqt_pkg::UidW-1:0] user;
  uqt_pkg::entry_t          ent;
  uqt_pkg::entry_t          ent_next;
  logic                     match;
  logic                     match_q;
  logic                     alloc_now;

  assign match     = in_use && (user == req.uid);
  assign alloc_now = ctl.alloc_write && alloc_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match;
    end
  end

  // merge the matched entry into the chain; at most one cell matches
  always_comb begin
    hit_out   = hit_in | match_q;
    chain_out = chain_in | ({$bits(uqt_pkg::entry_t){match_q}} & ent);
  end

  // a fresh entry starts from zero, then takes the same update as a hit
  always_comb begin
    ent_next = alloc_now ? '0 : ent;
    if (alloc_now || (ctl.hit_write && match_q)) begin
      unique case (req.op)
        uqt_pkg::OP_ADD_BLK: ent_next.bused = ent_next.bused + req.amount;
        uqt_pkg::OP_ADD_INO: ent_next.iused = ent_next.iused + req.amount;
        uqt_pkg::OP_SET: begin
          ent_next.bsoft = req.bsoft;
          ent_next.bhard = req.bhard;
          ent_next.isoft = req.isoft;
          ent_next.ihard = req.ihard;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_now) user <= req.uid;
    ent <= ent_next;
  end

endmodule

/* rtl/core/user_quota_table.sv */
// Top level of the user quota table: sequencer, cell row and result register.
//
//  channel | dir | fields
//  s_axis  | in  | operation, user_id, amount, four new limits
//  m_axis  | out | verdict, table_full, found, six stored fields
//
// A request is registered at accept; in the MATCH state every cell compares its
// key, and in the UPDATE state the matched cell is read and updated and the
// result is registered, which the OUT state then presents. A new request is
// accepted only once the result is taken.
// Reset empties the table (fill count to zero); stored data needs no clear.
// A stalled m_axis holds the result and blocks new requests.
module user_quota_table #(
  parameter int unsigned TABLE_DEPTH = uqt_pkg::DefaultDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0], user_id[34:3], amount[98:35], new_block_soft[162:99],
  // new_block_hard[226:163], new_inode_soft[290:227], new_inode_hard[354:291]
  input  logic [359:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict[1:0], table_full[2], found[3], blocks_in_use[67:4],
  // block_soft_out[131:68], block_hard_out[195:132], inodes_in_use[259:196],
  // inode_soft_out[323:260], inode_hard_out[387:324]
  output logic [391:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH + 1);

  uqt_pkg::state_t    state, state_next;
  uqt_pkg::req_t      req;
  uqt_pkg::cell_ctl_t ctl;
  logic [IdxW-1:0]    used;
  logic               full;

  uqt_pkg::entry_t chain [TABLE_DEPTH+1];
  logic            hits  [TABLE_DEPTH+1];

  assign chain[0] = '0;
  assign hits[0]  = 1'b0;
  assign full     = (used >= IdxW'(TABLE_DEPTH));

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    uqt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_use   (IdxW'(g) < used),
      .alloc_sel(IdxW'(g) == used),
      .ctl      (ctl),
      .req      (req),
      .chain_in (chain[g]),
      .hit_in   (hits[g]),
      .chain_out(chain[g+1]),
      .hit_out  (hits[g+1])
    );
  end

  localparam int unsigned CntLen = uqt_pkg::CntW;

  logic              hit;
  uqt_pkg::entry_t   e;
  logic              need_alloc;
  logic [CntLen:0]   total;
  logic [CntLen-1:0] soft_lim, hard_lim;
  logic [1:0]        verdict;
  logic              is_check;
  logic [391:0]      res;

  assign hit = hits[TABLE_DEPTH];
  assign e   = chain[TABLE_DEPTH];

  always_comb begin
    is_check = (req.op == uqt_pkg::OP_CHK_BLK) || (req.op == uqt_pkg::OP_CHK_INO);
    if (req.op == uqt_pkg::OP_CHK_BLK) begin
      total    = {1'b0, e.bused} + {1'b0, req.amount};
      soft_lim = e.bsoft;
      hard_lim = e.bhard;
    end else begin
      total    = {1'b0, e.iused} + {1'b0, req.amount};
      soft_lim = e.isoft;
      hard_lim = e.ihard;
    end
    if (!hit) begin
      // fresh entry: zero limits
      verdict = 2'd0;
    end else if (hard_lim == '0) begin
      verdict = 2'd0;
    end else if (total > {1'b0, hard_lim}) begin
      verdict = 2'd2;
    end else if (total > {1'b0, soft_lim}) begin
      verdict = 2'd1;
    end else begin
      verdict = 2'd0;
    end
    if (!is_check) verdict = 2'd0;
    need_alloc = !hit && !full && (req.op <= uqt_pkg::OP_SET);
  end

  always_comb begin
    res      = '0;
    res[1:0] = verdict;
    res[2]   = (req.op == uqt_pkg::OP_SET) && !hit && full;
    if (req.op == uqt_pkg::OP_LOOKUP && hit) begin
      res[3]       = 1'b1;
      res[67:4]    = e.bused;
      res[131:68]  = e.bsoft;
      res[195:132] = e.bhard;
      res[259:196] = e.iused;
      res[323:260] = e.isoft;
      res[387:324] = e.ihard;
    end
  end

  always_comb begin
    state_next      = state;
    ctl             = '0;
    s_axis_tready   = 1'b0;
    unique case (state)
      uqt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = uqt_pkg::ST_MATCH;
      end
      uqt_pkg::ST_MATCH: begin
        state_next = uqt_pkg::ST_UPDATE;
      end
      uqt_pkg::ST_UPDATE: begin
        ctl.hit_write   = 1'b1;
        ctl.alloc_write = need_alloc;
        state_next      = uqt_pkg::ST_OUT;
      end
      uqt_pkg::ST_OUT: begin
        if (m_axis_tready) state_next = uqt_pkg::ST_IDLE;
      end
      default: state_next = uqt_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = (state == uqt_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uqt_pkg::ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (ctl.alloc_write) used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req <= uqt_pkg::req_t'({s_axis_tdata[2:0], s_axis_tdata[34:3],
                              s_axis_tdata[98:35], s_axis_tdata[162:99],
                              s_axis_tdata[226:163], s_axis_tdata[290:227],
                              s_axis_tdata[354:291]});
    end
    if (state == uqt_pkg::ST_UPDATE) begin
      m_axis_tdata <= res;
    end
  end

endmodule
